[hdl/u8dec_pkg.sv]
// Shared types, constants and byte-class helpers for the UTF-8 decoder.
// Used by utf8_strict_lossy_decoder; no dependencies.
package u8dec_pkg;

  localparam logic [20:0] REPLACEMENT = 21'h00FFFD;
  localparam logic [20:0] MAX_SCALAR  = 21'h10FFFF;

  localparam logic [7:0] LEAD2_LO = 8'hc2;
  localparam logic [7:0] LEAD2_HI = 8'hdf;
  localparam logic [7:0] LEAD3_LO = 8'he0;
  localparam logic [7:0] LEAD3_HI = 8'hef;
  localparam logic [7:0] LEAD_E0  = 8'he0;
  localparam logic [7:0] LEAD_ED  = 8'hed;
  localparam logic [7:0] LEAD_F0  = 8'hf0;
  localparam logic [7:0] LEAD_F4  = 8'hf4;
  localparam logic [7:0] CONT_LO  = 8'h80;
  localparam logic [7:0] CONT_HI  = 8'hbf;
  localparam logic [7:0] E0_LO    = 8'ha0;
  localparam logic [7:0] ED_HI    = 8'h9f;
  localparam logic [7:0] F0_LO    = 8'h90;
  localparam logic [7:0] F4_HI    = 8'h8f;
  localparam logic [7:0] CONT_MASK = 8'hc0;

  // Input mode codes
  localparam logic MODE_DATA = 1'b0;
  localparam logic MODE_EOT  = 1'b1;

  typedef struct packed {
    logic       mode;
    logic [7:0] data_byte;
  } in_req_t;

  typedef struct packed {
    logic [20:0] scalar;
    logic        is_replacement;
    logic        last;
  } out_req_t;

  // Sequence length from a lead byte: 2, 3 or 4; 0 for a non-lead.
  function automatic logic [2:0] seq_len(input logic [7:0] lead);
    logic [2:0] len;
    len = 3'd0;
    if (lead inside {[LEAD2_LO:LEAD2_HI]}) begin
      len = 3'd2;
    end else if (lead inside {[LEAD3_LO:LEAD3_HI]}) begin
      len = 3'd3;
    end else if (lead inside {[LEAD_F0:LEAD_F4]}) begin
      len = 3'd4;
    end
    return len;
  endfunction

  // Range check on the byte right after the lead (Table 3-7).
  function automatic logic second_ok(input logic [7:0] lead, input logic [7:0] b);
    logic [7:0] lo;
    logic [7:0] hi;
    lo = CONT_LO;
    hi = CONT_HI;
    if (lead == LEAD_E0) begin
      lo = E0_LO;
    end else if (lead == LEAD_ED) begin
      hi = ED_HI;
    end else if (lead == LEAD_F0) begin
      lo = F0_LO;
    end else if (lead == LEAD_F4) begin
      hi = F4_HI;
    end
    return (b >= lo) && (b <= hi);
  endfunction

endpackage

[hdl/utf8_strict_lossy_decoder.sv]
// Strict UTF-8 decoder with U+FFFD replacement, one byte per request.
// Latency: the first result of a request is valid the cycle after it is taken.
// Throughput: one request per cycle while each yields at most one result and
// the output is not stalled; a request yielding n results (up to 4) stalls new
// requests while the single result register drains them, one per unstalled cycle.
// Reset (rst_ni low, async): nothing held, no result pending.
// Depends on u8dec_pkg.
module utf8_strict_lossy_decoder (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  u8dec_pkg::in_req_t  in_req_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output u8dec_pkg::out_req_t out_req_o
);

  // Pending sequence state
  logic [7:0]  held_lead_q,  held_lead_d;
  logic [1:0]  held_count_q, held_count_d;
  logic [5:0]  held_cont_q [2];
  logic        cont_we;
  logic        cont_sel;
  logic [5:0]  cont_wdata;

  // Result batch: remaining count, and the final result. All results ahead
  // of the final one are always U+FFFD replacements.
  logic [2:0]  rem_q,        rem_d;
  logic [20:0] fin_scalar_q, fin_scalar_d;
  logic        fin_repl_q,   fin_repl_d;

  logic        in_acc;
  logic        out_acc;

  assign out_valid_o = (rem_q != 3'd0);
  assign out_acc     = out_valid_o && !out_stall_i;
  // Take a new request only when the batch is empty or empties this cycle.
  assign in_stall_o  = (rem_q > 3'd1) || ((rem_q == 3'd1) && out_stall_i);
  assign in_acc      = in_valid_i && !in_stall_o;

  always_comb begin
    out_req_o.last           = (rem_q == 3'd1);
    out_req_o.scalar         = (rem_q == 3'd1) ? fin_scalar_q : u8dec_pkg::REPLACEMENT;
    out_req_o.is_replacement = (rem_q == 3'd1) ? fin_repl_q : 1'b1;
  end

  // Decode of one request
  always_comb begin
    logic [7:0]  b;
    logic [2:0]  need;
    logic        ok;
    logic        fresh_n;
    logic [20:0] fresh_scalar;
    logic        fresh_repl;
    logic        fresh_hold;
    logic [2:0]  n;
    logic [20:0] acc;

    b    = in_req_i.data_byte;
    need = u8dec_pkg::seq_len(held_lead_q);

    // Fresh decode of the byte with nothing held
    fresh_hold   = 1'b0;
    fresh_n      = 1'b1;
    fresh_scalar = u8dec_pkg::REPLACEMENT;
    fresh_repl   = 1'b1;
    if (!b[7]) begin
      fresh_scalar = {13'd0, b};
      fresh_repl   = 1'b0;
    end else if (u8dec_pkg::seq_len(b) != 3'd0) begin
      fresh_hold = 1'b1;
      fresh_n    = 1'b0;
    end

    if (held_count_q == 2'd1) begin
      ok = u8dec_pkg::second_ok(held_lead_q, b);
    end else begin
      ok = (b & u8dec_pkg::CONT_MASK) == u8dec_pkg::CONT_LO;
    end
    if ((need == 3'd0) || ({1'b0, held_count_q} >= need)) begin
      ok = 1'b0;
    end

    case (need)
      3'd2:    acc = {10'd0, held_lead_q[4:0], b[5:0]};
      3'd3:    acc = {5'd0, held_lead_q[3:0], held_cont_q[0], b[5:0]};
      default: acc = {held_lead_q[2:0], held_cont_q[0], held_cont_q[1], b[5:0]};
    endcase

    held_lead_d  = held_lead_q;
    held_count_d = held_count_q;
    cont_we      = 1'b0;
    cont_sel     = 1'b0;
    cont_wdata   = b[5:0];
    n            = 3'd0;
    fin_scalar_d = fin_scalar_q;
    fin_repl_d   = fin_repl_q;

    if (in_req_i.mode == u8dec_pkg::MODE_EOT) begin
      n            = {1'b0, held_count_q};
      fin_scalar_d = u8dec_pkg::REPLACEMENT;
      fin_repl_d   = 1'b1;
      held_lead_d  = 8'd0;
      held_count_d = 2'd0;
    end else if (held_count_q == 2'd0) begin
      n            = {2'd0, fresh_n};
      fin_scalar_d = fresh_scalar;
      fin_repl_d   = fresh_repl;
      if (fresh_hold) begin
        held_lead_d  = b;
        held_count_d = 2'd1;
      end
    end else if (ok) begin
      if (({1'b0, held_count_q} + 3'd1) == need) begin
        n            = 3'd1;
        fin_scalar_d = acc;
        fin_repl_d   = 1'b0;
        held_lead_d  = 8'd0;
        held_count_d = 2'd0;
      end else begin
        cont_we      = 1'b1;
        cont_sel     = held_count_q[1];  // count 1 -> slot 0, count 2 -> slot 1
        held_count_d = held_count_q + 2'd1;
      end
    end else begin
      // Failed sequence: flush held bytes, then decode this byte afresh.
      n            = {1'b0, held_count_q} + {2'd0, fresh_n};
      fin_scalar_d = fresh_n ? fresh_scalar : u8dec_pkg::REPLACEMENT;
      fin_repl_d   = fresh_n ? fresh_repl : 1'b1;
      held_lead_d  = fresh_hold ? b : 8'd0;
      held_count_d = fresh_hold ? 2'd1 : 2'd0;
    end

    if (in_acc) begin
      rem_d = n;
    end else if (out_acc) begin
      rem_d = rem_q - 3'd1;
    end else begin
      rem_d = rem_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_lead_q  <= 8'd0;
      held_count_q <= 2'd0;
      rem_q        <= 3'd0;
    end else begin
      rem_q <= rem_d;
      if (in_acc) begin
        held_lead_q  <= held_lead_d;
        held_count_q <= held_count_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      fin_scalar_q <= fin_scalar_d;
      fin_repl_q   <= fin_repl_d;
      if (cont_we) begin
        held_cont_q[cont_sel] <= cont_wdata;
      end
    end
  end

  // A held sequence always starts with a real lead byte.
  a_held_lead: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (held_count_q != 2'd0) |-> (u8dec_pkg::seq_len(held_lead_q) != 3'd0))
    else $error("held sequence without a valid lead");

  // Three bytes held only for a four-byte lead.
  a_held_three: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (held_count_q == 2'd3) |-> (u8dec_pkg::seq_len(held_lead_q) == 3'd4))
    else $error("three bytes held for a short sequence");

  // Every result ahead of the last one in a batch is a replacement.
  a_lead_repl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_req_o.last) |->
      (out_req_o.is_replacement && (out_req_o.scalar == u8dec_pkg::REPLACEMENT)))
    else $error("non-final result is not U+FFFD");

  // Decoded scalars stay in the Unicode range and never hit the surrogates.
  a_scalar_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((out_req_o.scalar <= u8dec_pkg::MAX_SCALAR) &&
                     (out_req_o.scalar[20:11] != 10'h01b)))
    else $error("scalar out of range");

  // At most four results per request.
  a_batch_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rem_q <= 3'd4)
    else $error("result batch too large");

endmodule

[tb/utf8_strict_lossy_decoder_tb.sv]
// Self-checking testbench for utf8_strict_lossy_decoder: directed and random byte
// streams, scoreboard fed by an in-file decoder predictor.
// Depends on u8dec_pkg and the decoder RTL only.
module utf8_strict_lossy_decoder_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_ITEMS  = 500;
  localparam int IDLE_PCT   = 12;
  localparam int CYCLE_CAP  = 200000;
  localparam int QUIET_FROM = 200;     // no idling on either side in this
  localparam int QUIET_TO   = 320;     // window of accepted requests
  localparam int DRAIN_WAIT = 8;

  // One queued request; drain_first holds it back until the scoreboard is empty.
  typedef struct {
    u8dec_pkg::in_req_t req;
    bit                 drain_first;
  } send_item_t;

  logic                clk_i;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_stall_o;
  u8dec_pkg::in_req_t  in_req_i;
  logic                out_valid_o;
  logic                out_stall_i;
  u8dec_pkg::out_req_t out_req_o;

  utf8_strict_lossy_decoder dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_req_o   (out_req_o)
  );

  send_item_t          pending_bytes[$];
  send_item_t          next_item;
  u8dec_pkg::out_req_t expected_scalars[$];
  bit                  drain_next;
  bit                  in_taken;
  int                  req_count;
  int                  cycle_count;
  int                  fail_count;
  logic                quiet;

  // Predictor state: the sequence currently being assembled.
  logic [7:0] pred_lead;
  logic [1:0] pred_count;
  logic [5:0] pred_cont[2];

  assign quiet = (req_count >= QUIET_FROM) && (req_count < QUIET_TO);

  always #2ns clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Decoder predictor
  // ---------------------------------------------------------------------------

  // Total sequence length implied by a lead byte, 0 if the byte cannot lead.
  function automatic int lead_len(input logic [7:0] b);
    if (b >= u8dec_pkg::LEAD2_LO && b <= u8dec_pkg::LEAD2_HI) return 2;
    if (b >= u8dec_pkg::LEAD3_LO && b <= u8dec_pkg::LEAD3_HI) return 3;
    if (b >= u8dec_pkg::LEAD_F0 && b <= u8dec_pkg::LEAD_F4) return 4;
    return 0;
  endfunction

  // The second byte has a narrowed range after E0, ED, F0 and F4; this is
  // what rules out overlongs, surrogates and values past U+10FFFF.
  function automatic bit second_in_range(input logic [7:0] lead, input logic [7:0] b);
    logic [7:0] lo;
    logic [7:0] hi;
    lo = u8dec_pkg::CONT_LO;
    hi = u8dec_pkg::CONT_HI;
    case (lead)
      u8dec_pkg::LEAD_E0: lo = u8dec_pkg::E0_LO;
      u8dec_pkg::LEAD_ED: hi = u8dec_pkg::ED_HI;
      u8dec_pkg::LEAD_F0: lo = u8dec_pkg::F0_LO;
      u8dec_pkg::LEAD_F4: hi = u8dec_pkg::F4_HI;
      default: ;
    endcase
    return (b >= lo) && (b <= hi);
  endfunction

  function automatic void push_scalar(input logic [20:0] value, input logic repl);
    u8dec_pkg::out_req_t r;
    r.scalar         = value;
    r.is_replacement = repl;
    r.last           = 1'b0;
    expected_scalars.insert(expected_scalars.size(), r);
  endfunction

  function automatic void clear_pending_seq();
    pred_lead  = 8'h00;
    pred_count = 2'd0;
  endfunction

  // A byte seen with nothing held: ASCII passes, a lead starts a sequence,
  // anything else (stray continuation, C0, C1, F5..FF) is replaced.
  function automatic void decode_lone_byte(input logic [7:0] b);
    if (b < u8dec_pkg::CONT_LO) begin
      push_scalar({13'd0, b}, 1'b0);
    end else if (lead_len(b) != 0) begin
      pred_lead  = b;
      pred_count = 2'd1;
    end else begin
      push_scalar(u8dec_pkg::REPLACEMENT, 1'b1);
    end
  endfunction

  // Works out every result one accepted request causes and queues them.
  function automatic void predict_decode(input u8dec_pkg::in_req_t req);
    int          base;
    int          need;
    bit          ok;
    logic [20:0] acc;
    logic [7:0]  din;
    base = expected_scalars.size();
    din  = req.data_byte;
    if (req.mode == u8dec_pkg::MODE_EOT) begin
      // flush: one replacement per held byte, lead included
      for (int i = 0; i < pred_count; i++) push_scalar(u8dec_pkg::REPLACEMENT, 1'b1);
      clear_pending_seq();
    end else if (pred_count == 2'd0) begin
      decode_lone_byte(din);
    end else begin
      need = lead_len(pred_lead);
      if (pred_count == 2'd1) ok = second_in_range(pred_lead, din);
      else ok = ((din & u8dec_pkg::CONT_MASK) == u8dec_pkg::CONT_LO);
      if (need == 0 || int'(pred_count) >= need) ok = 1'b0;
      if (ok) begin
        if (int'(pred_count) + 1 == need) begin
          if (need == 2) acc = {13'd0, pred_lead & 8'h1f};
          else if (need == 3) acc = {13'd0, pred_lead & 8'h0f};
          else acc = {13'd0, pred_lead & 8'h07};
          for (int i = 0; i + 1 < pred_count; i++) acc = (acc << 6) | {15'd0, pred_cont[i]};
          acc = (acc << 6) | {15'd0, din[5:0]};
          clear_pending_seq();
          push_scalar(acc, 1'b0);
        end else begin
          pred_cont[pred_count - 2'd1] = din[5:0];
          pred_count = pred_count + 2'd1;
        end
      end else begin
        // failed sequence: replace what is held, then re-decode this byte
        for (int i = 0; i < pred_count; i++) push_scalar(u8dec_pkg::REPLACEMENT, 1'b1);
        clear_pending_seq();
        decode_lone_byte(din);
      end
    end
    if (expected_scalars.size() > base)
      expected_scalars[expected_scalars.size() - 1].last = 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  task automatic queue_req(input logic mode, input logic [7:0] b);
    send_item_t it;
    it.req.mode      = mode;
    it.req.data_byte = b;
    it.drain_first   = drain_next;
    drain_next       = 1'b0;
    pending_bytes.insert(pending_bytes.size(), it);
  endtask

  task automatic queue_bytes(input logic [7:0] b[]);
    foreach (b[i]) queue_req(u8dec_pkg::MODE_DATA, b[i]);
  endtask

  // Encodes a scalar; sends only the first 'keep' bytes of it.
  task automatic queue_scalar(input int unsigned cp, input int keep);
    logic [7:0] enc[4];
    int         len;
    if (cp < 32'h80) begin
      len = 1;
      enc[0] = cp[7:0];
    end else if (cp < 32'h800) begin
      len = 2;
      enc[0] = 8'hc0 | {3'd0, cp[10:6]};
      enc[1] = 8'h80 | {2'd0, cp[5:0]};
    end else if (cp < 32'h10000) begin
      len = 3;
      enc[0] = 8'he0 | {4'd0, cp[15:12]};
      enc[1] = 8'h80 | {2'd0, cp[11:6]};
      enc[2] = 8'h80 | {2'd0, cp[5:0]};
    end else begin
      len = 4;
      enc[0] = 8'hf0 | {5'd0, cp[20:18]};
      enc[1] = 8'h80 | {2'd0, cp[17:12]};
      enc[2] = 8'h80 | {2'd0, cp[11:6]};
      enc[3] = 8'h80 | {2'd0, cp[5:0]};
    end
    for (int i = 0; i < len && i < keep; i++) queue_req(u8dec_pkg::MODE_DATA, enc[i]);
  endtask

  // Random well-formed scalar of 1..4 encoded bytes, surrogates excluded.
  function automatic int unsigned rand_scalar();
    int unsigned cp;
    case ($urandom_range(1, 4))
      1: cp = $urandom_range(32'h0, 32'h7f);
      2: cp = $urandom_range(32'h80, 32'h7ff);
      3: begin
        cp = $urandom_range(32'h800, 32'hffff);
        if (cp >= 32'hd800 && cp <= 32'hdfff) cp = cp ^ 32'h2000;
      end
      default: cp = $urandom_range(32'h10000, 32'h10ffff);
    endcase
    return cp;
  endfunction

  function automatic int enc_len(input int unsigned cp);
    return (cp < 32'h80) ? 1 : (cp < 32'h800) ? 2 : (cp < 32'h10000) ? 3 : 4;
  endfunction

  task automatic build_stimulus();
    int unsigned cp;
    int          roll;
    int          len;
    bit          mid_drain;
    mid_drain = 1'b0;
    // directed: ASCII bounds, 2/3/4-byte bounds, the narrowed second-byte
    // ranges, bad leads, stray continuation, a four-result failure, flushes
    queue_bytes('{8'h00, 8'h7f});
    queue_bytes('{8'hdf, 8'hbf});
    queue_bytes('{8'he0, 8'ha0, 8'h80});
    queue_bytes('{8'hed, 8'ha0});                 // surrogate lead then stray
    queue_bytes('{8'hf4, 8'h8f, 8'hbf, 8'hbf});   // U+10FFFF
    queue_bytes('{8'hf0, 8'h90, 8'h80, 8'h41});   // three held, then ASCII
    queue_bytes('{8'hc0, 8'hff, 8'h80});
    queue_bytes('{8'he2, 8'h82});
    queue_req(u8dec_pkg::MODE_EOT, 8'h00);        // flush two held bytes
    queue_req(u8dec_pkg::MODE_EOT, 8'hff);        // flush with nothing held
    queue_bytes('{8'hf4, 8'h90});                 // above U+10FFFF
    drain_next = 1'b1;                            // sender waits for a drain here
    // random: mostly well-formed text with broken sequences and noise mixed in
    while (pending_bytes.size() < NUM_ITEMS) begin
      if (!mid_drain && pending_bytes.size() >= NUM_ITEMS / 2) begin
        drain_next = 1'b1;
        mid_drain  = 1'b1;
      end
      roll = $urandom_range(0, 99);
      cp   = rand_scalar();
      len  = enc_len(cp);
      if (roll < 70 || len == 1) begin
        queue_scalar(cp, 4);
      end else if (roll < 80) begin
        // truncated sequence, cut by a random byte or an end of text
        queue_scalar(cp, $urandom_range(1, len - 1));
        if ($urandom_range(0, 1)) queue_req(u8dec_pkg::MODE_DATA, 8'($urandom_range(0, 255)));
        else queue_req(u8dec_pkg::MODE_EOT, 8'($urandom_range(0, 255)));
      end else if (roll < 88) begin
        queue_req(u8dec_pkg::MODE_DATA, 8'($urandom_range(0, 255)));
      end else if (roll < 94) begin
        queue_req(u8dec_pkg::MODE_EOT, 8'($urandom_range(0, 255)));
      end else begin
        // a random byte from C0..FF (a lead or an invalid byte) followed by an arbitrary continuation-range byte
        queue_req(u8dec_pkg::MODE_DATA, 8'($urandom_range(8'hc0, 8'hff)));
        queue_req(u8dec_pkg::MODE_DATA, 8'($urandom_range(8'h80, 8'hbf)));
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Driver: new requests and output stall change on the falling edge
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (rst_ni) begin
      out_stall_i <= !quiet && ($urandom_range(0, 99) < IDLE_PCT);
      // a stalled request stays put; otherwise offer the next one or idle
      if (!in_valid_i || in_taken) begin
        if (pending_bytes.size() != 0 &&
            !(pending_bytes[0].drain_first && expected_scalars.size() != 0) &&
            (quiet || $urandom_range(0, 99) >= IDLE_PCT)) begin
          next_item = pending_bytes.pop_front();
          in_req_i   <= next_item.req;
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: handshakes sampled on the rising edge
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    in_taken = rst_ni && in_valid_i && !in_stall_o;
    if (in_taken) begin
      predict_decode(in_req_i);
      req_count++;
    end
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_scalars.size() == 0) begin
        $error("unexpected result: scalar %h repl %b last %b",
               out_req_o.scalar, out_req_o.is_replacement, out_req_o.last);
        fail_count++;
      end else begin
        if (out_req_o.scalar !== expected_scalars[0].scalar) begin
          $error("scalar: expected %h, got %h", expected_scalars[0].scalar, out_req_o.scalar);
          fail_count++;
        end
        if (out_req_o.is_replacement !== expected_scalars[0].is_replacement) begin
          $error("is_replacement: expected %b, got %b",
                 expected_scalars[0].is_replacement, out_req_o.is_replacement);
          fail_count++;
        end
        if (out_req_o.last !== expected_scalars[0].last) begin
          $error("last: expected %b, got %b", expected_scalars[0].last, out_req_o.last);
          fail_count++;
        end
        void'(expected_scalars.pop_front());
      end
    end
  end

  // Hang guard
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_CAP) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    clk_i       = 1'b0;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_req_i    = '0;
    out_stall_i = 1'b0;
    in_taken    = 1'b0;
    drain_next  = 1'b0;
    req_count   = 0;
    cycle_count = 0;
    fail_count  = 0;
    pred_cont[0] = '0;
    pred_cont[1] = '0;
    clear_pending_seq();
    build_stimulus();
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;
    // all requests taken, then all results in, then an idle wait set by
    // DRAIN_WAIT to catch anything extra
    wait (pending_bytes.size() == 0 && !in_valid_i);
    wait (expected_scalars.size() == 0);
    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

[utf8_strict_lossy_decoder.f]
hdl/u8dec_pkg.sv
hdl/utf8_strict_lossy_decoder.sv
tb/utf8_strict_lossy_decoder_tb.sv
